// ===== rtl/core/ssi_pkg.sv =====
// shared types, constants and helpers for the sorted set insert block
`timescale 1ns / 1ps

package ssi_pkg;

    localparam int CAPACITY = 128;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 2;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_DUP      = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_RES
    } t_state;

    typedef struct packed {
        logic cmp_en;
        logic write_en;
    } t_cell_ctrl;

    // one-hot to binary index
    function automatic logic [IDX_W-1:0] onehot_to_idx(input logic [CAPACITY-1:0] onehot);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (onehot[k]) begin
                idx = idx | k[IDX_W-1:0];
            end
        end
        return idx;
    endfunction

endpackage

// ===== rtl/core/sorted_set_insert_top.sv =====
// top level of the sorted set insert block
`timescale 1ns / 1ps

// Holds up to 128 distinct signed 32-bit values in ascending order in a row of
// compare-and-shift cells. Each request is handled in order: the value is
// latched, then every cell compares its entry with it in parallel, then the
// insertion slot is encoded and all larger entries move up one cell at once.
// The block works on one request at a time and takes a new one only after the
// last one has been committed. A finished result sits in an output register; a
// new request is accepted while it waits, but the commit cycle stalls until the
// result slot is free. Status is 0 inserted, 1 duplicate (position of the
// existing entry), 2 full (position 0, store unchanged). element_count is the
// number of entries after the request. Cells above the count hold no meaning
// and need no clearing after reset.
module sorted_set_insert_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [ssi_pkg::VAL_W-1:0]  i_value,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [ssi_pkg::STAT_W-1:0] o_status,
    output logic [ssi_pkg::IDX_W-1:0]  o_position,
    output logic [ssi_pkg::CNT_W-1:0]  o_element_count
);

    // control state
    ssi_pkg::t_state               r_state, n_state;
    logic [ssi_pkg::CNT_W-1:0]     r_count, n_count;
    logic                          r_out_valid, n_out_valid;

    // payload registers
    logic [ssi_pkg::VAL_W-1:0]     r_key;
    ssi_pkg::t_status              r_status, n_status;
    logic [ssi_pkg::IDX_W-1:0]     r_position, n_position;
    logic [ssi_pkg::CNT_W-1:0]     r_count_out, n_count_out;

    ssi_pkg::t_cell_ctrl           cell_ctrl;
    logic                          key_load;

    // per-cell flags and values along the row
    logic [ssi_pkg::CAPACITY-1:0]  occupied;
    logic [ssi_pkg::CAPACITY-1:0]  ge;
    logic [ssi_pkg::CAPACITY-1:0]  eq;
    logic [ssi_pkg::CAPACITY-1:0]  slot_onehot;
    logic [ssi_pkg::VAL_W-1:0]     cell_value [ssi_pkg::CAPACITY];

    logic                          full;
    logic                          dup;
    logic [ssi_pkg::IDX_W-1:0]     slot_idx;

    // the row of cells; cell 0 has no left neighbor
    for (genvar g = 0; g < ssi_pkg::CAPACITY; g++) begin : g_cell
        logic                      left_ge;
        logic [ssi_pkg::VAL_W-1:0] left_value;

        if (g == 0) begin : g_first
            assign left_ge    = 1'b0;
            assign left_value = r_key;
        end else begin : g_rest
            assign left_ge    = ge[g-1];
            assign left_value = cell_value[g-1];
        end

        assign occupied[g] = (ssi_pkg::CNT_W'(g) < r_count);

        ssi_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (cell_ctrl),
            .i_occupied   (occupied[g]),
            .i_key        (r_key),
            .i_left_ge    (left_ge),
            .i_left_value (left_value),
            .o_ge         (ge[g]),
            .o_eq         (eq[g]),
            .o_value      (cell_value[g])
        );
    end

    // the insertion slot is the first cell that is not below the key
    assign slot_onehot = ge & ~{ge[ssi_pkg::CAPACITY-2:0], 1'b0};
    assign slot_idx    = ssi_pkg::onehot_to_idx(slot_onehot);
    assign dup         = |(slot_onehot & eq);
    assign full        = (r_count == ssi_pkg::CNT_W'(ssi_pkg::CAPACITY));

    // sequencer: latch, compare, commit
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_ready;
        n_status    = r_status;
        n_position  = r_position;
        n_count_out = r_count_out;
        cell_ctrl   = '0;
        key_load    = 1'b0;
        o_ready     = 1'b0;
        unique case (r_state)
            ssi_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    key_load = 1'b1;
                    n_state  = ssi_pkg::S_CMP;
                end
            end
            ssi_pkg::S_CMP: begin
                cell_ctrl.cmp_en = 1'b1;
                n_state          = ssi_pkg::S_RES;
            end
            ssi_pkg::S_RES: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_state     = ssi_pkg::S_IDLE;
                    if (full) begin
                        n_status   = ssi_pkg::ST_FULL;
                        n_position = '0;
                    end else if (dup) begin
                        n_status   = ssi_pkg::ST_DUP;
                        n_position = slot_idx;
                    end else begin
                        n_status           = ssi_pkg::ST_INSERTED;
                        n_position         = slot_idx;
                        n_count            = r_count + 1'b1;
                        cell_ctrl.write_en = 1'b1;
                    end
                    n_count_out = n_count;
                end
            end
            default: begin
                n_state = ssi_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssi_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload: key and result fields
    always_ff @(posedge i_clk) begin
        if (key_load) begin
            r_key <= i_value;
        end
        r_status    <= n_status;
        r_position  <= n_position;
        r_count_out <= n_count_out;
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_position      = r_position;
    assign o_element_count = r_count_out;

    // a full store never reports a slot
    a_full_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ssi_pkg::ST_FULL) |-> (o_position == '0))
        else $error("full result with nonzero position");

    // an insert grows the store by exactly one
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_ctrl.write_en |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not advance count");

    // count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ssi_pkg::CNT_W'(ssi_pkg::CAPACITY))
        else $error("count above capacity");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status) && $stable(o_position)))
        else $error("pending result lost");

endmodule

// ===== rtl/core/ssi_cell.sv =====
// one compare-and-shift cell of the sorted store
`timescale 1ns / 1ps

module ssi_cell (
    input  logic                      i_clk,
    input  ssi_pkg::t_cell_ctrl       i_ctrl,
    input  logic                      i_occupied,
    input  logic [ssi_pkg::VAL_W-1:0] i_key,
    input  logic                      i_left_ge,
    input  logic [ssi_pkg::VAL_W-1:0] i_left_value,
    output logic                      o_ge,
    output logic                      o_eq,
    output logic [ssi_pkg::VAL_W-1:0] o_value
);

    logic [ssi_pkg::VAL_W-1:0] r_value;
    logic                      r_ge;
    logic                      r_eq;

    // empty slots count as "not below", so the first empty slot takes an append
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp_en) begin
            r_ge <= !i_occupied || ($signed(r_value) >= $signed(i_key));
            r_eq <= i_occupied && (r_value == i_key);
        end
        if (i_ctrl.write_en && r_ge) begin
            r_value <= i_left_ge ? i_left_value : i_key;
        end
    end

    assign o_ge    = r_ge;
    assign o_eq    = r_eq;
    assign o_value = r_value;

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for the sorted set insert block
`timescale 1ns / 1ps

module testbench;

    // quiet cycles tolerated before the run is declared hung; the worst legal
    // stretch is a long sender gap plus a long receiver stall plus the core's own work
    localparam int WATCHDOG_LIMIT = 2000;
    // settling cycles after the last result
    localparam int DRAIN_CYCLES   = 16;
    localparam int RANDOM_ITEMS   = 1500;
    localparam int FLAT_OUT_ITEMS = 400;
    localparam int FULL_ITEMS     = 120;

    typedef struct {
        ssi_pkg::t_status                 status;
        logic [ssi_pkg::IDX_W-1:0]        position;
        logic [ssi_pkg::CNT_W-1:0]        count;
    } t_insert_result;

    logic                         i_clk   = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic [ssi_pkg::VAL_W-1:0]    i_value = '0;
    logic                         i_ready = 1'b0;
    logic                         o_ready;
    logic                         o_valid;
    logic [ssi_pkg::STAT_W-1:0]   o_status;
    logic [ssi_pkg::IDX_W-1:0]    o_position;
    logic [ssi_pkg::CNT_W-1:0]    o_element_count;

    // shadow copy of the sorted store, updated when an accepted request inserts
    logic signed [ssi_pkg::VAL_W-1:0] set_store [ssi_pkg::CAPACITY];
    int                               set_count = 0;

    // results still owed by the block, oldest first
    t_insert_result expected_results [$];

    // idling switches, flipped by the test tasks
    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;

    int requests_sent   = 0;
    int inserts_seen    = 0;
    int dups_seen       = 0;
    int fulls_seen      = 0;
    int results_checked = 0;
    int mismatches      = 0;
    int random_left     = RANDOM_ITEMS;
    int rx_hold         = 0;

    sorted_set_insert_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_value         (i_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_position      (o_position),
        .o_element_count (o_element_count)
    );

    always #2 i_clk = ~i_clk;

    // gap length: mostly short, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // sorted insert on the shadow store; returns what the block must report
    function automatic t_insert_result predict_insert(
        input logic signed [ssi_pkg::VAL_W-1:0] v
    );
        t_insert_result r;
        int slot;
        r.status   = ssi_pkg::ST_INSERTED;
        r.position = '0;
        if (set_count >= ssi_pkg::CAPACITY) begin
            // full wins over duplicate, store untouched
            r.status = ssi_pkg::ST_FULL;
            fulls_seen++;
        end else begin
            // first entry that is not below the new value
            slot = set_count;
            for (int k = 0; k < set_count; k++) begin
                if (set_store[k] >= v) begin
                    slot = k;
                    break;
                end
            end
            r.position = slot[ssi_pkg::IDX_W-1:0];
            if (slot < set_count && set_store[slot] == v) begin
                r.status = ssi_pkg::ST_DUP;
                dups_seen++;
            end else begin
                // larger entries move up one slot
                for (int k = set_count; k > slot; k--) begin
                    set_store[k] = set_store[k-1];
                end
                set_store[slot] = v;
                set_count++;
                inserts_seen++;
            end
        end
        r.count = set_count[ssi_pkg::CNT_W-1:0];
        return r;
    endfunction

    // one request: optional idle gap, then hold valid until the handshake
    task automatic send_value(input logic [ssi_pkg::VAL_W-1:0] v);
        int gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 1) == 1) begin
            gap = gap_len();
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (!o_ready);
        // accepted at this edge, predict in acceptance order
        expected_results.push_back(predict_insert($signed(v)));
        requests_sent++;
    endtask

    // a value already in the store, or anything when the store is empty
    function automatic logic [ssi_pkg::VAL_W-1:0] pick_present();
        if (set_count == 0) begin
            return $urandom;
        end
        return set_store[$urandom_range(0, set_count - 1)];
    endfunction

    // a likely-new value: wide random, a neighbor of an entry, or near zero
    function automatic logic [ssi_pkg::VAL_W-1:0] pick_fresh();
        int r;
        logic [ssi_pkg::VAL_W-1:0] base;
        r = $urandom_range(0, 9);
        if (r < 4 || set_count == 0) begin
            return $urandom;
        end
        if (r < 7) begin
            base = pick_present();
            return ($urandom_range(0, 1) == 1) ? base + 1 : base - 1;
        end
        return $unsigned($signed($urandom_range(0, 64)) - 32);
    endfunction

    // random requests, mostly hits on stored values so the store fills slowly;
    // the chance of a fresh value tracks the free slots over the items left
    task automatic run_random(input int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, random_left - 1) < ssi_pkg::CAPACITY - set_count) begin
                send_value(pick_fresh());
            end else begin
                send_value(pick_present());
            end
            random_left--;
        end
    endtask

    // empty store, extremes of the value range, front, append, middle, duplicates
    task automatic test_empty_and_extremes();
        logic [ssi_pkg::VAL_W-1:0] corner_values [16];
        corner_values = '{
            32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
            32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001,
            32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0002, 32'h7FFF_FFFE,
            32'h8000_0001, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF
        };
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        foreach (corner_values[k]) begin
            send_value(corner_values[k]);
        end
    endtask

    // full rate on both sides
    task automatic test_back_to_back();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_random(FLAT_OUT_ITEMS);
    endtask

    // random gaps on the sender and random stalls on the receiver
    task automatic test_random_with_idling();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        run_random(RANDOM_ITEMS - FLAT_OUT_ITEMS);
    endtask

    // top off the store, then hit it with stored, new and extreme values
    task automatic test_full_store();
        int r;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        while (set_count < ssi_pkg::CAPACITY) begin
            send_value($urandom);
        end
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        for (int k = 0; k < FULL_ITEMS; k++) begin
            r = $urandom_range(0, 2);
            if (r == 0) begin
                send_value(pick_present());
            end else if (r == 1) begin
                send_value(pick_fresh());
            end else begin
                send_value($urandom);
            end
        end
    endtask

    // receiver: ready by default, stalls of random length when enabled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            i_ready <= 1'b0;
            rx_hold--;
        end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
            i_ready <= 1'b0;
            rx_hold = gap_len() - 1;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // every accepted result against the oldest outstanding prediction
    always @(posedge i_clk) begin : check_results
        t_insert_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $error("result with no request outstanding: status %0d position %0d count %0d",
                       o_status, o_position, o_element_count);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatches++;
                end
                if (o_position !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position, o_position);
                    mismatches++;
                end
                if (o_element_count !== want.count) begin
                    $error("element_count: expected %0d, got %0d", want.count, o_element_count);
                    mismatches++;
                end
            end
        end
    end

    // hang detection: too long without any handshake ends the run
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("timeout after %0d cycles without a handshake", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_and_extremes();
        test_back_to_back();
        test_random_with_idling();
        test_full_store();
        i_valid <= 1'b0;

        // wait for the last results, then settle for DRAIN_CYCLES to catch stray outputs
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests: %0d inserted, %0d duplicates, %0d refused on a full store",
                 requests_sent, inserts_seen, dups_seen, fulls_seen);
        $display("%0d results compared, %0d field mismatches", results_checked, mismatches);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
